>>> src/pmbd_pkg.sv
// Shared constants, codes and controller/datapath interface types for the bootstrap draw block.
`timescale 1ns / 1ps

package pmbd_pkg;

  localparam int DEF_MAX_SAMPLES = 256;
  localparam int DEF_MAX_COEFS   = 8;

  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int ACT_W     = 3;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 3;
  localparam int MAG_W     = 31;
  localparam int CIDX_W    = 3;
  localparam int SC_W      = 9;
  localparam int CC_W      = 4;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [ACT_W-1:0] ACT_RESIDUAL   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DESIGN     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_WEIGHT     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SCALING    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_MULTIPLIER = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RUN        = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_COUNT   = 1'b1;

  localparam logic [ACC_W-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_DIFF,
    OP_SQ,
    OP_CU,
    OP_KERN,
    OP_SMUL,
    OP_SSAT,
    OP_XMUL,
    OP_XACC,
    OP_MOP,
    OP_MHI,
    OP_MLO,
    OP_MCOMB,
    OP_MSUM,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   phase;    // 0: weight pass, 1: scaling pass
    logic   row_end;
    logic   last;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

>>> src/pairwise_multiplier_bootstrap_draw.sv
// Top level of the pairwise multiplier-bootstrap draw engine: config registers and wiring.
`timescale 1ns / 1ps

// Load beats (residual, design, weight, scaling, multiplier) give no result. A run beat sums,
// for every ordered pair i != j of the first n observations and every coefficient k, the
// design-row difference times the clipped cubic kernel of the residual difference times the sum
// of the two multipliers, in Q15.16 with 64-bit wrapping accumulators; then applies the weight
// and then the scaling matrix with saturation, divides by n(n-1) and emits p result beats
// |value| (saturated), the last one flagged. One shared sequencer visits each pair and each
// coefficient lane in turn, the matrix passes share one 32x32 multiplier, and the divider
// produces one quotient bit a cycle. Input is accepted only between runs; a result beat waits
// in the output register without holding off the next input.

module pairwise_multiplier_bootstrap_draw #(
  parameter int MAX_SAMPLES = pmbd_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_COEFS   = pmbd_pkg::DEF_MAX_COEFS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pmbd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pmbd_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pmbd_pkg::ACT_W-1:0]          action_i,
  input  logic [pmbd_pkg::ROW_W-1:0]          row_index_i,
  input  logic [pmbd_pkg::COL_W-1:0]          col_index_i,
  input  logic signed [pmbd_pkg::DATA_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pmbd_pkg::CIDX_W-1:0]         coef_index_o,
  output logic [pmbd_pkg::MAG_W-1:0]          magnitude_o,
  output logic                                last_o
);

  localparam int SW = $clog2(MAX_SAMPLES);
  localparam int CW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
  localparam int NW = $clog2(MAX_SAMPLES + 1);
  localparam int PW = $clog2(MAX_COEFS + 1);
  localparam logic [31:0] MAXS = 32'(MAX_SAMPLES);
  localparam logic [31:0] MAXC = 32'(MAX_COEFS);

  logic [pmbd_pkg::SC_W-1:0] sample_count_q;
  logic [pmbd_pkg::CC_W-1:0] coef_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= pmbd_pkg::SC_W'(2);
      coef_count_q   <= pmbd_pkg::CC_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pmbd_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i;
        pmbd_pkg::CFG_COEF_COUNT:   coef_count_q   <= cfg_data_i[pmbd_pkg::CC_W-1:0];
        default: ;
      endcase
    end
  end

  logic [31:0]   n_full, p_full;
  logic [NW-1:0] n_eff;
  logic [PW-1:0] p_eff;

  assign n_full = (32'(sample_count_q) > MAXS) ? MAXS : 32'(sample_count_q);
  assign p_full = (32'(coef_count_q) > MAXC) ? MAXC : 32'(coef_count_q);
  assign n_eff  = NW'(n_full);
  assign p_eff  = PW'(p_full);

  pmbd_pkg::cmd_t    cmd;
  pmbd_pkg::status_t status;
  logic [SW-1:0]     idx_i, idx_j;
  logic [CW-1:0]     idx_k, idx_r;

  pmbd_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_COEFS   (MAX_COEFS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .n_i        (n_eff),
    .p_i        (p_eff),
    .status_i   (status),
    .cmd_o      (cmd),
    .i_o        (idx_i),
    .j_o        (idx_j),
    .k_o        (idx_k),
    .r_o        (idx_r)
  );

  pmbd_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_COEFS   (MAX_COEFS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .i_i          (idx_i),
    .j_i          (idx_j),
    .k_i          (idx_k),
    .r_i          (idx_r),
    .n_i          (n_eff),
    .action_i     (action_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .coef_index_o (coef_index_o),
    .magnitude_o  (magnitude_o),
    .last_o       (last_o)
  );

endmodule

>>> src/pmbd_datapath.sv
// Datapath: stores, kernel and pair arithmetic, matrix products, divider and result register.
`timescale 1ns / 1ps

module pmbd_datapath #(
  parameter int MAX_SAMPLES = pmbd_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_COEFS   = pmbd_pkg::DEF_MAX_COEFS,
  localparam int SW = $clog2(MAX_SAMPLES),
  localparam int CW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1,
  localparam int NW = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pmbd_pkg::cmd_t                  cmd_i,
  output pmbd_pkg::status_t               status_o,
  input  logic [SW-1:0]                   i_i,
  input  logic [SW-1:0]                   j_i,
  input  logic [CW-1:0]                   k_i,
  input  logic [CW-1:0]                   r_i,
  input  logic [NW-1:0]                   n_i,
  input  logic [pmbd_pkg::ACT_W-1:0]      action_i,
  input  logic [pmbd_pkg::ROW_W-1:0]      row_index_i,
  input  logic [pmbd_pkg::COL_W-1:0]      col_index_i,
  input  logic signed [pmbd_pkg::DATA_W-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pmbd_pkg::CIDX_W-1:0]     coef_index_o,
  output logic [pmbd_pkg::MAG_W-1:0]      magnitude_o,
  output logic                            last_o
);

  localparam int DEPTH_D = MAX_SAMPLES * MAX_COEFS;
  localparam int DEPTH_M = MAX_COEFS * MAX_COEFS;
  localparam int DA = (DEPTH_D > 1) ? $clog2(DEPTH_D) : 1;
  localparam int WA = (DEPTH_M > 1) ? $clog2(DEPTH_M) : 1;
  localparam int DW = 2 * NW;
  localparam logic [31:0] MAXS = 32'(MAX_SAMPLES);
  localparam logic [31:0] MAXC = 32'(MAX_COEFS);

  // stores
  logic signed [31:0] res_mem [MAX_SAMPLES];
  logic signed [31:0] mul_mem [MAX_SAMPLES];
  logic signed [31:0] des_mem [DEPTH_D];
  logic signed [31:0] wgt_mem [DEPTH_M];
  logic signed [31:0] scl_mem [DEPTH_M];

  logic signed [31:0] e_i_q, e_j_q, z_i_q, z_j_q, x_i_q, x_j_q, w_rd_q, s_rd_q;

  logic row_ok_s, row_ok_c, col_ok, load;
  logic [SW-1:0] smp_waddr;
  logic [DA-1:0] des_waddr, des_ra_i, des_ra_j;
  logic [WA-1:0] mat_waddr, mat_ra;

  assign load      = (cmd_i.op == pmbd_pkg::OP_LOAD);
  assign row_ok_s  = 32'(row_index_i) < MAXS;
  assign row_ok_c  = 32'(row_index_i) < MAXC;
  assign col_ok    = 32'(col_index_i) < MAXC;
  assign smp_waddr = SW'(row_index_i);
  assign des_waddr = DA'(32'(row_index_i) * MAXC + 32'(col_index_i));
  assign mat_waddr = WA'(32'(row_index_i) * MAXC + 32'(col_index_i));
  assign des_ra_i  = DA'(32'(i_i) * MAXC + 32'(k_i));
  assign des_ra_j  = DA'(32'(j_i) * MAXC + 32'(k_i));
  assign mat_ra    = WA'(32'(r_i) * MAXC + 32'(k_i));

  always_ff @(posedge clk_i) begin
    if (load && action_i == pmbd_pkg::ACT_RESIDUAL && row_ok_s) begin
      res_mem[smp_waddr] <= value_i;
    end
    if (load && action_i == pmbd_pkg::ACT_MULTIPLIER && row_ok_s) begin
      mul_mem[smp_waddr] <= value_i;
    end
    if (load && action_i == pmbd_pkg::ACT_DESIGN && row_ok_s && col_ok) begin
      des_mem[des_waddr] <= value_i;
    end
    if (load && action_i == pmbd_pkg::ACT_WEIGHT && row_ok_c && col_ok) begin
      wgt_mem[mat_waddr] <= value_i;
    end
    if (load && action_i == pmbd_pkg::ACT_SCALING && row_ok_c && col_ok) begin
      scl_mem[mat_waddr] <= value_i;
    end
    e_i_q  <= res_mem[i_i];
    e_j_q  <= res_mem[j_i];
    z_i_q  <= mul_mem[i_i];
    z_j_q  <= mul_mem[j_i];
    x_i_q  <= des_mem[des_ra_i];
    x_j_q  <= des_mem[des_ra_j];
    w_rd_q <= wgt_mem[mat_ra];
    s_rd_q <= scl_mem[mat_ra];
  end

  // kernel and pair arithmetic
  logic signed [32:0] d_q, zs_q;
  logic [15:0]        sq_q;
  logic signed [17:0] cu_q, l_q;
  logic signed [50:0] sprod_q;
  logic signed [31:0] s_q;
  logic signed [64:0] xprod_q;

  logic signed [16:0] ds;
  logic signed [33:0] sq_prod, cu_prod;
  logic [33:0]        cu_adj;
  logic signed [19:0] kv;
  logic [19:0]        kv_adj;
  logic               clip_hi, clip_lo;
  logic signed [17:0] l_d;
  logic [50:0]        s_adj;
  logic [31:0]        s_d;
  logic signed [32:0] xd;
  logic [64:0]        x_adj;
  logic signed [63:0] term;

  assign ds      = d_q[16:0];
  assign clip_hi = d_q >= 33'sd65536;
  assign clip_lo = d_q <= -33'sd65536;
  assign sq_prod = 34'(ds) * 34'(ds);
  assign cu_prod = 34'(ds) * 34'(signed'({1'b0, sq_q}));
  assign cu_adj  = cu_prod + {18'd0, {16{cu_prod[33]}}};
  assign kv      = 20'(ds) + 20'(ds) + 20'(ds) - 20'(cu_q);
  assign kv_adj  = kv + 20'(kv[19]);

  always_comb begin
    if (clip_hi) begin
      l_d = 18'sd65536;
    end else if (clip_lo) begin
      l_d = -18'sd65536;
    end else begin
      l_d = kv_adj[18:1];
    end
  end

  // divide by 2^16 rounds toward zero: bias negatives before the shift
  assign s_adj = sprod_q + {35'd0, {16{sprod_q[50]}}};
  always_comb begin
    if (s_adj[50:47] != {4{s_adj[50]}}) begin
      s_d = s_adj[50] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      s_d = s_adj[47:16];
    end
  end

  assign xd    = 33'(x_i_q) - 33'(x_j_q);
  assign x_adj = xprod_q + {49'd0, {16{xprod_q[64]}}};
  assign term  = 64'(signed'(x_adj[64:16]));

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      pmbd_pkg::OP_DIFF: begin
        d_q  <= 33'(e_i_q) - 33'(e_j_q);
        zs_q <= 33'(z_i_q) + 33'(z_j_q);
      end
      pmbd_pkg::OP_SQ:   sq_q    <= sq_prod[31:16];
      pmbd_pkg::OP_CU:   cu_q    <= cu_adj[33:16];
      pmbd_pkg::OP_KERN: l_q     <= l_d;
      pmbd_pkg::OP_SMUL: sprod_q <= 51'(l_q) * 51'(zs_q);
      pmbd_pkg::OP_SSAT: s_q     <= s_d;
      pmbd_pkg::OP_XMUL: xprod_q <= 65'(xd) * 65'(s_q);
      default: ;
    endcase
  end

  // saturating Q16 matrix products, one shared 32x32 multiplier
  logic signed [63:0] acc_q [MAX_COEFS];
  logic signed [63:0] t_q   [MAX_COEFS];
  logic [63:0]        ma_q, hb_q, lo_q;
  logic [31:0]        mb_q;
  logic               neg_q;
  logic signed [63:0] pm_q, sum_q;

  logic [63:0] op_a, mag, pm_d, sum_raw, sum_new;
  logic [31:0] op_b, mul_x;
  logic [63:0] mul_p;
  logic        ovf;

  assign op_a    = cmd_i.phase ? t_q[k_i] : acc_q[k_i];
  assign op_b    = cmd_i.phase ? s_rd_q : w_rd_q;
  assign mul_x   = (cmd_i.op == pmbd_pkg::OP_MHI) ? ma_q[63:32] : ma_q[31:0];
  assign mul_p   = 64'(mul_x) * 64'(mb_q);
  assign mag     = (hb_q[63:47] != '0) ? pmbd_pkg::S64_MIN
                                       : {hb_q[46:0], 16'd0} + {16'd0, lo_q[63:16]};
  assign pm_d    = neg_q ? (mag[63] ? pmbd_pkg::S64_MIN : -mag)
                         : (mag[63] ? pmbd_pkg::S64_MAX : mag);
  assign sum_raw = sum_q + pm_q;
  assign ovf     = (sum_q[63] == pm_q[63]) && (sum_raw[63] != sum_q[63]);
  assign sum_new = ovf ? (sum_q[63] ? pmbd_pkg::S64_MIN : pmbd_pkg::S64_MAX) : sum_raw;

  // divider by n(n-1), one quotient bit a cycle
  logic [DW-1:0] nn1_q, rem_q;
  logic          nlt2_q;
  logic [63:0]   quo_q;
  logic [5:0]    div_cnt_q;
  logic          div_busy_q;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic          div_start;

  assign div_start = (cmd_i.op == pmbd_pkg::OP_MSUM) && cmd_i.row_end && cmd_i.phase;
  assign rem_sh    = {rem_q, quo_q[63]};
  assign ge        = rem_sh >= {1'b0, nn1_q};

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      pmbd_pkg::OP_INIT: begin
        nn1_q  <= DW'(n_i) * DW'(n_i - NW'(1));
        nlt2_q <= n_i < NW'(2);
      end
      pmbd_pkg::OP_MOP: begin
        neg_q <= op_a[63] ^ op_b[31];
        ma_q  <= op_a[63] ? -op_a : op_a;
        mb_q  <= op_b[31] ? -op_b : op_b;
      end
      pmbd_pkg::OP_MHI:   hb_q <= mul_p;
      pmbd_pkg::OP_MLO:   lo_q <= mul_p;
      pmbd_pkg::OP_MCOMB: pm_q <= pm_d;
      default: ;
    endcase
    if (cmd_i.op == pmbd_pkg::OP_MSUM && cmd_i.row_end && !cmd_i.phase) begin
      t_q[r_i] <= sum_new;
    end
    if (div_start) begin
      quo_q <= sum_new[63] ? -sum_new : sum_new;
      rem_q <= '0;
    end else if (div_busy_q) begin
      rem_q <= ge ? DW'(rem_sh - {1'b0, nn1_q}) : rem_sh[DW-1:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_COEFS; c++) begin
        acc_q[c] <= '0;
      end
      sum_q      <= '0;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      if (cmd_i.op == pmbd_pkg::OP_INIT) begin
        for (int c = 0; c < MAX_COEFS; c++) begin
          acc_q[c] <= '0;
        end
        sum_q <= '0;
      end
      if (cmd_i.op == pmbd_pkg::OP_XACC) begin
        acc_q[k_i] <= acc_q[k_i] + term;   // wraps modulo 2^64
      end
      if (cmd_i.op == pmbd_pkg::OP_MSUM) begin
        sum_q <= cmd_i.row_end ? '0 : sum_new;
      end
      if (div_start) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= '0;
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q + 6'd1;
        if (div_cnt_q == 6'd63) begin
          div_busy_q <= 1'b0;
        end
      end
    end
  end

  // result register
  logic                          out_valid_q;
  logic [pmbd_pkg::CIDX_W-1:0]   cidx_q;
  logic [pmbd_pkg::MAG_W-1:0]    mag_q;
  logic                          last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == pmbd_pkg::OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == pmbd_pkg::OP_OUT) begin
      cidx_q <= pmbd_pkg::CIDX_W'(r_i);
      last_q <= cmd_i.last;
      if (nlt2_q) begin
        mag_q <= '0;
      end else if (quo_q[63:31] != '0) begin
        mag_q <= 31'h7FFF_FFFF;
      end else begin
        mag_q <= quo_q[30:0];
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign coef_index_o      = cidx_q;
  assign magnitude_o       = mag_q;
  assign last_o            = last_q;
  assign status_o.div_busy = div_busy_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == pmbd_pkg::OP_OUT) |-> !div_busy_q)
    else $error("result taken while divider busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (div_busy_q && div_cnt_q == 6'd0))
    else $error("divider did not start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == pmbd_pkg::OP_OUT) |=> out_valid_o)
    else $error("result beat lost");

endmodule

>>> src/pmbd_ctrl.sv
// Controller: sequences loads, the pair loop, both matrix passes and result beats.
`timescale 1ns / 1ps

module pmbd_ctrl #(
  parameter int MAX_SAMPLES = pmbd_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_COEFS   = pmbd_pkg::DEF_MAX_COEFS,
  localparam int SW = $clog2(MAX_SAMPLES),
  localparam int CW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1,
  localparam int NW = $clog2(MAX_SAMPLES + 1),
  localparam int PW = $clog2(MAX_COEFS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pmbd_pkg::ACT_W-1:0] action_i,
  input  logic [NW-1:0]              n_i,
  input  logic [PW-1:0]              p_i,
  input  pmbd_pkg::status_t          status_i,
  output pmbd_pkg::cmd_t             cmd_o,
  output logic [SW-1:0]              i_o,
  output logic [SW-1:0]              j_o,
  output logic [CW-1:0]              k_o,
  output logic [CW-1:0]              r_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_NXT, S_PRD, S_PD, S_SQ, S_CU, S_KL, S_SM, S_SS,
    S_XRD, S_XM, S_XA, S_MRD, S_MOP, S_MHI, S_MLO, S_MCB, S_MSM, S_DIV
  } state_e;

  state_e        state_q;
  logic [SW-1:0] i_q, j_q;
  logic [CW-1:0] k_q, r_q;
  logic          phase_q;

  logic last_k, last_r, last_i, last_j, out_go;

  assign last_k = (PW'(k_q) + PW'(1)) == p_i;
  assign last_r = (PW'(r_q) + PW'(1)) == p_i;
  assign last_i = (NW'(i_q) + NW'(1)) == n_i;
  assign last_j = (NW'(j_q) + NW'(1)) == n_i;
  assign out_go = !status_i.div_busy && status_i.out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign i_o = i_q;
  assign j_o = j_q;
  assign k_o = k_q;
  assign r_o = r_q;

  always_comb begin
    cmd_o.op      = pmbd_pkg::OP_NONE;
    cmd_o.phase   = phase_q;
    cmd_o.row_end = last_k;
    cmd_o.last    = last_r;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && action_i != pmbd_pkg::ACT_RUN) begin
          cmd_o.op = pmbd_pkg::OP_LOAD;
        end
      end
      S_INIT: cmd_o.op = pmbd_pkg::OP_INIT;
      S_PD:   cmd_o.op = pmbd_pkg::OP_DIFF;
      S_SQ:   cmd_o.op = pmbd_pkg::OP_SQ;
      S_CU:   cmd_o.op = pmbd_pkg::OP_CU;
      S_KL:   cmd_o.op = pmbd_pkg::OP_KERN;
      S_SM:   cmd_o.op = pmbd_pkg::OP_SMUL;
      S_SS:   cmd_o.op = pmbd_pkg::OP_SSAT;
      S_XM:   cmd_o.op = pmbd_pkg::OP_XMUL;
      S_XA:   cmd_o.op = pmbd_pkg::OP_XACC;
      S_MOP:  cmd_o.op = pmbd_pkg::OP_MOP;
      S_MHI:  cmd_o.op = pmbd_pkg::OP_MHI;
      S_MLO:  cmd_o.op = pmbd_pkg::OP_MLO;
      S_MCB:  cmd_o.op = pmbd_pkg::OP_MCOMB;
      S_MSM:  cmd_o.op = pmbd_pkg::OP_MSUM;
      S_DIV: begin
        if (out_go) begin
          cmd_o.op = pmbd_pkg::OP_OUT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      r_q     <= '0;
      phase_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && action_i == pmbd_pkg::ACT_RUN) begin
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          i_q     <= '0;
          j_q     <= '0;
          k_q     <= '0;
          r_q     <= '0;
          phase_q <= 1'b0;
          if (p_i == '0) begin
            state_q <= S_IDLE;
          end else if (n_i < NW'(2)) begin
            state_q <= S_MRD;
          end else begin
            state_q <= S_NXT;   // steps off the (0,0) diagonal first
          end
        end
        S_NXT: begin
          if (last_j) begin
            if (last_i) begin
              state_q <= S_MRD;
            end else begin
              i_q     <= i_q + SW'(1);
              j_q     <= '0;
              state_q <= S_PRD;
            end
          end else begin
            j_q <= j_q + SW'(1);
            // landing on the diagonal: advance once more
            state_q <= ((j_q + SW'(1)) == i_q) ? S_NXT : S_PRD;
          end
        end
        S_PRD: state_q <= S_PD;
        S_PD:  state_q <= S_SQ;
        S_SQ:  state_q <= S_CU;
        S_CU:  state_q <= S_KL;
        S_KL:  state_q <= S_SM;
        S_SM:  state_q <= S_SS;
        S_SS:  state_q <= S_XRD;
        S_XRD: state_q <= S_XM;
        S_XM:  state_q <= S_XA;
        S_XA: begin
          if (last_k) begin
            k_q     <= '0;
            state_q <= S_NXT;
          end else begin
            k_q     <= k_q + CW'(1);
            state_q <= S_XRD;
          end
        end
        S_MRD: state_q <= S_MOP;
        S_MOP: state_q <= S_MHI;
        S_MHI: state_q <= S_MLO;
        S_MLO: state_q <= S_MCB;
        S_MCB: state_q <= S_MSM;
        S_MSM: begin
          if (last_k) begin
            k_q <= '0;
            if (phase_q) begin
              state_q <= S_DIV;
            end else begin
              if (last_r) begin
                phase_q <= 1'b1;
                r_q     <= '0;
              end else begin
                r_q <= r_q + CW'(1);
              end
              state_q <= S_MRD;
            end
          end else begin
            k_q     <= k_q + CW'(1);
            state_q <= S_MRD;
          end
        end
        S_DIV: begin
          if (out_go) begin
            if (last_r) begin
              state_q <= S_IDLE;
            end else begin
              r_q     <= r_q + CW'(1);
              state_q <= S_MRD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PRD) |-> (i_q != j_q))
    else $error("diagonal pair entered the kernel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PRD) |-> (NW'(i_q) < n_i && NW'(j_q) < n_i))
    else $error("pair index beyond sample count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XA || state_q == S_MSM) |-> (PW'(k_q) < p_i))
    else $error("coefficient lane beyond coef count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MSM && phase_q && last_k) |=> status_i.div_busy)
    else $error("divider not started at end of scaling row");

endmodule
